@@ sv/gtp_pkg.sv @@
// GUID text parser package: character constants, list pattern and helpers.
// Used by the channel interfaces and by guid_text_parser_top.
package gtp_pkg;

	localparam int unsigned CuW      = 16;
	localparam int unsigned ListLen  = 47;
	localparam int unsigned StepW    = 6;
	localparam int unsigned DashLen  = 36;

	localparam logic [CuW-1:0] ChDash   = 16'h002D;
	localparam logic [CuW-1:0] ChBrOpen = 16'h007B;
	localparam logic [CuW-1:0] ChBrShut = 16'h007D;
	localparam logic [CuW-1:0] ChPaOpen = 16'h0028;
	localparam logic [CuW-1:0] ChPaShut = 16'h0029;
	localparam logic [CuW-1:0] ChLowX   = 16'h0078;
	localparam logic [CuW-1:0] ChUpX    = 16'h0058;

	localparam logic [7:0] PatHex = 8'h48;
	localparam logic [7:0] PatX   = 8'h78;

	typedef enum logic [1:0] {
		FORM_DASHED = 2'd0,
		FORM_LIST   = 2'd1,
		FORM_BARE   = 2'd2
	} form_t;

	typedef enum logic [1:0] {
		CLOSE_NONE  = 2'd0,
		CLOSE_BRACE = 2'd1,
		CLOSE_PAREN = 2'd2
	} closer_t;

	function automatic logic is_space(input logic [CuW-1:0] c);
		return (c >= 16'h0009 && c <= 16'h000D) || (c >= 16'h2000 && c <= 16'h200A) ||
			c == 16'h0020 || c == 16'h0085 || c == 16'h00A0 || c == 16'h1680 ||
			c == 16'h180E || c == 16'h2028 || c == 16'h2029 || c == 16'h202F ||
			c == 16'h205F || c == 16'h3000;
	endfunction

	// bit 4 set when c is a hex digit, bits 3:0 its value
	function automatic logic [4:0] hex_val(input logic [CuW-1:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 16'h0030 && c <= 16'h0039)
			r = {1'b1, c[3:0]};
		else if ((c >= 16'h0061 && c <= 16'h0066) || (c >= 16'h0041 && c <= 16'h0046))
			r = {1'b1, c[3:0] + 4'd9};
		return r;
	endfunction

	// {0xH,0xH,0xH,{0xH,0xH,0xH,0xH,0xH,0xH,0xH,0xH}}
	function automatic logic [7:0] list_pat(input logic [StepW-1:0] s);
		logic [7:0] r;
		r = 8'h2C;
		if (s == 6'd0 || s == 6'd13)
			r = 8'h7B;
		else if (s == 6'd45 || s == 6'd46)
			r = 8'h7D;
		else if (s < 6'd13) begin
			case (s[1:0])
				2'd1:    r = 8'h30;
				2'd2:    r = PatX;
				2'd3:    r = PatHex;
				default: r = 8'h2C;
			endcase
		end else if (s < 6'd45) begin
			case (s[1:0])
				2'd2:    r = 8'h30;
				2'd3:    r = PatX;
				2'd0:    r = PatHex;
				default: r = 8'h2C;
			endcase
		end
		return r;
	endfunction

	// hex digits allowed in the field at step s
	function automatic logic [3:0] field_digits(input logic [StepW-1:0] s);
		if (s == 6'd3)
			return 4'd8;
		if (s == 6'd7 || s == 6'd11)
			return 4'd4;
		return 4'd2;
	endfunction

endpackage

@@ sv/gtp_text_if.sv @@
// Input channel: one UTF-16 code unit per beat.
// Depends on gtp_pkg.
interface gtp_text_if import gtp_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [CuW-1:0] code_unit;
	modport source (output valid, output code_unit, input ready);
	modport sink (input valid, input code_unit, output ready);
endinterface

@@ sv/gtp_guid_if.sv @@
// Result channel: one parsed GUID per beat.
// Depends on gtp_pkg.
interface gtp_guid_if import gtp_pkg::*; ();
	logic        valid;
	logic        ready;
	logic        status;
	logic [1:0]  form;
	logic [31:0] part_one;
	logic [15:0] part_two;
	logic [15:0] part_three;
	logic [15:0] tail_head;
	logic [47:0] tail_rest;
	modport source (output valid, output status, output form, output part_one,
		output part_two, output part_three, output tail_head, output tail_rest, input ready);
	modport sink (input valid, input status, input form, input part_one,
		input part_two, input part_three, input tail_head, input tail_rest, output ready);
endinterface

@@ sv/guid_text_parser_top.sv @@
// GUID text parser top level: three recognizers and a result register.
// Depends on gtp_pkg, gtp_text_if and gtp_guid_if.
// Throughput: one code unit per cycle; a zero unit's result is valid the next cycle.
// The result register holds a beat until taken; text is stalled only while it is full
// and not being taken.
// Reset (arst_n, asynchronous) clears all parse state and empties the result register.
module guid_text_parser_top import gtp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	gtp_text_if.sink    text,
	gtp_guid_if.source  guid
);

	logic              lead_q, pend_q, saw_dash_q, saw_brace_q;
	logic [StepW-1:0]  dpos_q;
	closer_t           dclose_q;
	logic              dfail_q;
	logic [127:0]      dbits_q;
	logic [StepW-1:0]  bpos_q;
	logic              bfail_q;
	logic [127:0]      bbits_q;
	logic [StepW-1:0]  lstep_q;
	logic [3:0]        ldig_q;
	logic              lany_q, lfail_q;
	logic [127:0]      lbits_q;
	logic              ovalid_q;

	logic              take;
	logic [CuW-1:0]    c;
	logic [4:0]        hv;

	logic              lead_d, pend_d, saw_dash_d, saw_brace_d;
	logic [StepW-1:0]  dpos_d;
	closer_t           dclose_d;
	logic              dfail_d;
	logic [127:0]      dbits_d;
	logic [StepW-1:0]  bpos_d;
	logic              bfail_d;
	logic [127:0]      bbits_d;
	logic [StepW-1:0]  lstep_d, ls2, ls3;
	logic [3:0]        ldig_d, ndig;
	logic              lany_d, lfail_d;
	logic [127:0]      lbits_d;
	logic [7:0]        pch;
	logic              pmatch;
	logic              ok;
	form_t             form;
	logic [127:0]      res;

	assign text.ready = !ovalid_q || guid.ready;
	assign take = text.valid && text.ready;
	assign c = text.code_unit;
	assign hv = hex_val(c);

	always_comb begin
		lead_d = lead_q; pend_d = pend_q; saw_dash_d = saw_dash_q; saw_brace_d = saw_brace_q;
		dpos_d = dpos_q; dclose_d = dclose_q; dfail_d = dfail_q; dbits_d = dbits_q;
		bpos_d = bpos_q; bfail_d = bfail_q; bbits_d = bbits_q;
		lstep_d = lstep_q; ldig_d = ldig_q; lany_d = lany_q; lfail_d = lfail_q;
		lbits_d = lbits_q;
		ls2 = lstep_q; ls3 = lstep_q; ndig = ldig_q; pch = list_pat(lstep_q); pmatch = 1'b0;
		if (is_space(c)) begin
			if (!lead_q)
				pend_d = 1'b1;
		end else begin
			lead_d = 1'b0;
			pend_d = 1'b0;
			dfail_d = dfail_q || pend_q;
			bfail_d = bfail_q || pend_q;
			if (c == ChDash)
				saw_dash_d = 1'b1;
			if (c == ChBrOpen)
				saw_brace_d = 1'b1;

			// dashed
			if (!dfail_d) begin
				if (dpos_q == '0 && dclose_q == CLOSE_NONE && (c == ChBrOpen || c == ChPaOpen))
					dclose_d = (c == ChBrOpen) ? CLOSE_BRACE : CLOSE_PAREN;
				else if (dpos_q < StepW'(DashLen)) begin
					if (dpos_q == 6'd8 || dpos_q == 6'd13 || dpos_q == 6'd18 || dpos_q == 6'd23) begin
						if (c != ChDash)
							dfail_d = 1'b1;
						else
							dpos_d = dpos_q + 1'b1;
					end else if (!hv[4])
						dfail_d = 1'b1;
					else begin
						dbits_d = {dbits_q[123:0], hv[3:0]};
						dpos_d = dpos_q + 1'b1;
					end
				end else if (dpos_q == StepW'(DashLen) &&
					((dclose_q == CLOSE_BRACE && c == ChBrShut) ||
					 (dclose_q == CLOSE_PAREN && c == ChPaShut)))
					dpos_d = StepW'(DashLen + 1);
				else
					dfail_d = 1'b1;
			end

			// bare
			if (!bfail_d) begin
				if (bpos_q >= 6'd32 || !hv[4])
					bfail_d = 1'b1;
				else begin
					bbits_d = {bbits_q[123:0], hv[3:0]};
					bpos_d = bpos_q + 1'b1;
				end
			end

			// braced list
			if (!lfail_q) begin
				if (lstep_q >= StepW'(ListLen))
					lfail_d = 1'b1;
				else if (pch == PatHex && hv[4]) begin
					ndig = ldig_q + {3'd0, (ldig_q != '0 || hv[3:0] != '0)};
					if (ndig > field_digits(lstep_q))
						lfail_d = 1'b1;
					else begin
						ldig_d = ndig;
						lany_d = 1'b1;
						case (field_digits(lstep_q))
							4'd8:    lbits_d[31:0] = {lbits_q[27:0], hv[3:0]};
							4'd4:    lbits_d[15:0] = {lbits_q[11:0], hv[3:0]};
							default: lbits_d[7:0]  = {lbits_q[3:0], hv[3:0]};
						endcase
					end
				end else if (pch == PatHex && !lany_q)
					lfail_d = 1'b1;
				else begin
					if (pch == PatHex)
						ls2 = lstep_q + 1'b1;
					pch = list_pat(ls2);
					pmatch = (pch == PatX) ? (c == ChLowX || c == ChUpX) : (c == {8'd0, pch});
					if (!pmatch)
						lfail_d = 1'b1;
					else begin
						ls3 = ls2 + 1'b1;
						lstep_d = ls3;
						if (ls3 < StepW'(ListLen) && list_pat(ls3) == PatHex) begin
							ldig_d = '0;
							lany_d = 1'b0;
							case (field_digits(ls3))
								4'd8:    lbits_d = {lbits_q[95:0], 32'd0};
								4'd4:    lbits_d = {lbits_q[111:0], 16'd0};
								default: lbits_d = {lbits_q[119:0], 8'd0};
							endcase
						end
					end
				end
			end
		end
	end

	always_comb begin
		if (saw_dash_q) begin
			form = FORM_DASHED;
			ok = !dfail_q && dpos_q == ((dclose_q != CLOSE_NONE) ? StepW'(DashLen + 1) :
				StepW'(DashLen));
			res = dbits_q;
		end else if (saw_brace_q) begin
			form = FORM_LIST;
			ok = !lfail_q && lstep_q == StepW'(ListLen);
			res = lbits_q;
		end else begin
			form = FORM_BARE;
			ok = !bfail_q && bpos_q == 6'd32;
			res = bbits_q;
		end
		if (!ok)
			res = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= 1'b1; pend_q <= 1'b0; saw_dash_q <= 1'b0; saw_brace_q <= 1'b0;
			dpos_q <= '0; dclose_q <= CLOSE_NONE; dfail_q <= 1'b0; dbits_q <= '0;
			bpos_q <= '0; bfail_q <= 1'b0; bbits_q <= '0;
			lstep_q <= '0; ldig_q <= '0; lany_q <= 1'b0; lfail_q <= 1'b0; lbits_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			ovalid_q <= (take && c == '0) || (ovalid_q && !guid.ready);
			if (take && c == '0) begin
				lead_q <= 1'b1; pend_q <= 1'b0; saw_dash_q <= 1'b0; saw_brace_q <= 1'b0;
				dpos_q <= '0; dclose_q <= CLOSE_NONE; dfail_q <= 1'b0; dbits_q <= '0;
				bpos_q <= '0; bfail_q <= 1'b0; bbits_q <= '0;
				lstep_q <= '0; ldig_q <= '0; lany_q <= 1'b0; lfail_q <= 1'b0; lbits_q <= '0;
			end else if (take) begin
				lead_q <= lead_d; pend_q <= pend_d; saw_dash_q <= saw_dash_d;
				saw_brace_q <= saw_brace_d;
				dpos_q <= dpos_d; dclose_q <= dclose_d; dfail_q <= dfail_d; dbits_q <= dbits_d;
				bpos_q <= bpos_d; bfail_q <= bfail_d; bbits_q <= bbits_d;
				lstep_q <= lstep_d; ldig_q <= ldig_d; lany_q <= lany_d; lfail_q <= lfail_d;
				lbits_q <= lbits_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && c == '0) begin
			guid.status     <= !ok;
			guid.form       <= form;
			guid.part_one   <= res[127:96];
			guid.part_two   <= res[95:80];
			guid.part_three <= res[79:64];
			guid.tail_head  <= res[63:48];
			guid.tail_rest  <= res[47:0];
		end
	end

	assign guid.valid = ovalid_q;

endmodule
